[design/umwb_pkg.sv]
// Shared types and constants for the unit move / wall bounce pipeline.
// No dependencies; used by every module of the block.
package umwb_pkg;

  localparam int unsigned NumAxes = 3;
  localparam int unsigned SqrtStages = 32;
  localparam int unsigned DivStages = 28;
  localparam int unsigned FrontStages = 2;
  localparam int unsigned BackStages = 2;

  localparam int unsigned CfgIdxW = 8;
  localparam int unsigned CfgDataW = 32;

  typedef enum logic [CfgIdxW-1:0] {
    CfgTimeStep = 8'd0,
    CfgBoundX   = 8'd1,
    CfgBoundY   = 8'd2,
    CfgBoundZ   = 8'd3
  } cfg_idx_e;

  localparam logic signed [15:0] DirMin = 16'sh8000;
  localparam logic signed [15:0] DirMax = 16'sh7fff;

  typedef struct packed {
    logic [NumAxes-1:0][31:0] pos;
    logic [NumAxes-1:0][15:0] dir;
    logic                     move;
  } item_t;

endpackage

[design/unit_move_with_wall_bounce.sv]
// Top level of the unit move / wall bounce pipeline: ports, config, stall control.
// Depends on umwb_pkg, umwb_front, umwb_sqrt, umwb_div, umwb_back.
//
//  channel | direction | handshake              | words
//  --------+-----------+------------------------+--------------------------------
//  in      | to block  | in_valid_i/in_stall_o  | pos, dir, speed, active
//  out     | from block| out_valid_o/out_stall_i| new_pos, new_dir
//  cfg     | to block  | cfg_valid_i/cfg_ready_o| register index, write data
//
// One word enters per cycle while the output is not stalled; the pipeline is the 32-stage square
// root and the 28-stage divider, plus two front and two back stages.
// Reset clears the valid bits and loads the register reset values.
// A stalled output word freezes the whole pipeline and stalls the input;
// bubbles inside the pipeline are not squeezed out while the output is held.
module unit_move_with_wall_bounce (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] pos_x_i,
  input  logic [31:0] pos_y_i,
  input  logic [31:0] pos_z_i,
  input  logic [15:0] dir_x_i,
  input  logic [15:0] dir_y_i,
  input  logic [15:0] dir_z_i,
  input  logic [15:0] speed_i,
  input  logic        active_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] new_pos_x_o,
  output logic [31:0] new_pos_y_o,
  output logic [31:0] new_pos_z_o,
  output logic [15:0] new_dir_x_o,
  output logic [15:0] new_dir_y_o,
  output logic [15:0] new_dir_z_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [umwb_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [umwb_pkg::CfgDataW-1:0] cfg_data_i
);
  import umwb_pkg::*;

  localparam int unsigned Lat = FrontStages + SqrtStages + DivStages + BackStages;
  localparam int unsigned ItemDly = SqrtStages + DivStages;

  // Configuration registers.
  logic [15:0]      time_step_q;
  logic [2:0][30:0] bound_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_step_q <= 16'd256;
      bound_q <= {3{31'd16777216}};
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CfgTimeStep: time_step_q <= cfg_data_i[15:0];
        CfgBoundX:   bound_q[0] <= cfg_data_i[30:0];
        CfgBoundY:   bound_q[1] <= cfg_data_i[30:0];
        CfgBoundZ:   bound_q[2] <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  // Advance everything unless the output word is held.
  logic en;
  logic [Lat-1:0] vld_q;

  assign en = !(vld_q[Lat-1] && out_stall_i);
  assign in_stall_o = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Lat-2:0], in_valid_i};
    end
  end

  assign out_valid_o = vld_q[Lat-1];

  // Front: squares, norm sum and step numerators.
  item_t            f_item;
  logic [31:0]      f_sum;
  logic [2:0][47:0] f_num, f_num_alt;

  umwb_front u_front (
    .clk_i      (clk_i),
    .en_i       (en),
    .pos_x_i    (pos_x_i),
    .pos_y_i    (pos_y_i),
    .pos_z_i    (pos_z_i),
    .dir_x_i    (dir_x_i),
    .dir_y_i    (dir_y_i),
    .dir_z_i    (dir_z_i),
    .speed_i    (speed_i),
    .active_i   (active_i),
    .time_step_i(time_step_q),
    .item_o     (f_item),
    .sum_o      (f_sum),
    .num_o      (f_num),
    .num_alt_o  (f_num_alt)
  );

  // Norm in Q.16.
  logic [31:0] norm;

  umwb_sqrt u_sqrt (
    .clk_i (clk_i),
    .en_i  (en),
    .op_i  (f_sum),
    .root_o(norm)
  );

  // Hold numerators while the root is computed.
  logic [SqrtStages-1:0][2:0][47:0] num_dly_q, num_alt_dly_q;
  logic [ItemDly-1:0] [$bits(item_t)-1:0] item_dly_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      num_dly_q <= {num_dly_q[SqrtStages-2:0], f_num};
      num_alt_dly_q <= {num_alt_dly_q[SqrtStages-2:0], f_num_alt};
      item_dly_q <= {item_dly_q[ItemDly-2:0], f_item};
    end
  end

  // Step magnitudes per axis, for the own heading and the saturated reflection.
  logic [2:0][27:0] quo, quo_alt;

  for (genvar a = 0; a < 3; a++) begin : g_axis
    umwb_div u_div (
      .clk_i(clk_i),
      .en_i (en),
      .num_i(num_dly_q[SqrtStages-1][a]),
      .den_i(norm),
      .quo_o(quo[a])
    );
    umwb_div u_div_alt (
      .clk_i(clk_i),
      .en_i (en),
      .num_i(num_alt_dly_q[SqrtStages-1][a]),
      .den_i(norm),
      .quo_o(quo_alt[a])
    );
  end

  // Back: reflect, move, saturate; its last stage is the output register.
  logic [2:0][31:0] res_pos;
  logic [2:0][15:0] res_dir;

  umwb_back u_back (
    .clk_i    (clk_i),
    .en_i     (en),
    .item_i   (item_t'(item_dly_q[ItemDly-1])),
    .quo_i    (quo),
    .quo_alt_i(quo_alt),
    .bound_i  (bound_q),
    .pos_o    (res_pos),
    .dir_o    (res_dir)
  );

  assign new_pos_x_o = res_pos[0];
  assign new_pos_y_o = res_pos[1];
  assign new_pos_z_o = res_pos[2];
  assign new_dir_x_o = res_dir[0];
  assign new_dir_y_o = res_dir[1];
  assign new_dir_z_o = res_dir[2];

endmodule

[design/umwb_front.sv]
// Front end: squares, speed*time product, heading norm sum, step numerators.
// Depends on umwb_pkg.
module umwb_front (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  logic [31:0]            pos_x_i,
  input  logic [31:0]            pos_y_i,
  input  logic [31:0]            pos_z_i,
  input  logic [15:0]            dir_x_i,
  input  logic [15:0]            dir_y_i,
  input  logic [15:0]            dir_z_i,
  input  logic [15:0]            speed_i,
  input  logic                   active_i,
  input  logic [15:0]            time_step_i,
  output umwb_pkg::item_t        item_o,
  output logic [31:0]            sum_o,
  output logic [2:0][47:0]       num_o,
  output logic [2:0][47:0]       num_alt_o
);
  import umwb_pkg::*;

  item_t            item_d, item1_q, item2_q;
  logic [2:0][30:0] sq_q;
  logic [2:0][15:0] mag_d, mag_q, mag_alt_d, mag_alt_q;
  logic [31:0]      prod_q;
  logic [31:0]      sum_q;
  logic [2:0][47:0] num_q, num_alt_q;

  always_comb begin
    item_d.pos = {pos_z_i, pos_y_i, pos_x_i};
    item_d.dir = {dir_z_i, dir_y_i, dir_x_i};
    item_d.move = active_i && ((dir_x_i != '0) || (dir_y_i != '0) || (dir_z_i != '0));
    for (int a = 0; a < 3; a++) begin
      mag_d[a] = item_d.dir[a][15] ? (~item_d.dir[a] + 16'd1) : item_d.dir[a];
      mag_alt_d[a] = ($signed(item_d.dir[a]) == DirMin) ? DirMax : mag_d[a];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      item1_q <= item_d;
      for (int a = 0; a < 3; a++) begin
        sq_q[a] <= 31'($signed(item_d.dir[a]) * $signed(item_d.dir[a]));
      end
      mag_q <= mag_d;
      mag_alt_q <= mag_alt_d;
      prod_q <= speed_i * time_step_i;
      item2_q <= item1_q;
      sum_q <= 32'(sq_q[0]) + 32'(sq_q[1]) + 32'(sq_q[2]);
      for (int a = 0; a < 3; a++) begin
        num_q[a] <= prod_q * mag_q[a];
        num_alt_q[a] <= prod_q * mag_alt_q[a];
      end
    end
  end

  assign item_o = item2_q;
  assign sum_o = sum_q;
  assign num_o = num_q;
  assign num_alt_o = num_alt_q;

endmodule

[design/umwb_sqrt.sv]
// Pipelined integer square root of (op << 32), one root bit per stage.
// Depends on umwb_pkg.
module umwb_sqrt (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [31:0] op_i,
  output logic [31:0] root_o
);
  import umwb_pkg::*;

  logic [SqrtStages-1:0][33:0] rem_q;
  logic [SqrtStages-1:0][31:0] root_q;
  logic [SqrtStages-1:0][31:0] op_q;

  for (genvar k = 0; k < SqrtStages; k++) begin : g_stage
    logic [33:0] rem_in;
    logic [31:0] root_in, op_in;
    logic [1:0]  pair;
    logic [35:0] rem_sh, trial;
    logic [33:0] rem_d;
    logic [31:0] root_d;

    if (k == 0) begin : g_first
      assign rem_in = '0;
      assign root_in = '0;
      assign op_in = op_i;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign op_in = op_q[k-1];
    end

    // Upper half of the radicand comes from op, lower half is zero.
    if (k < 16) begin : g_hi
      assign pair = op_in[31-2*k -: 2];
    end else begin : g_lo
      assign pair = 2'b00;
    end

    always_comb begin
      rem_sh = {rem_in, pair};
      trial = {2'b00, root_in, 2'b01};
      if (rem_sh >= trial) begin
        rem_d = 34'(rem_sh - trial);
        root_d = {root_in[30:0], 1'b1};
      end else begin
        rem_d = rem_sh[33:0];
        root_d = {root_in[30:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= rem_d;
        root_q[k] <= root_d;
        op_q[k] <= op_in;
      end
    end
  end

  assign root_o = root_q[SqrtStages-1];

endmodule

[design/umwb_div.sv]
// Pipelined restoring divider: (num << 12) / den, one quotient bit per stage.
// Depends on umwb_pkg; quotient is known to fit 28 bits.
module umwb_div (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [47:0] num_i,
  input  logic [31:0] den_i,
  output logic [27:0] quo_o
);
  import umwb_pkg::*;

  logic [DivStages-1:0][31:0] rem_q;
  logic [DivStages-1:0][27:0] quo_q;
  logic [DivStages-1:0][31:0] den_q;
  logic [DivStages-1:0][27:0] low_q;

  for (genvar k = 0; k < DivStages; k++) begin : g_stage
    logic [31:0] rem_in, den_in;
    logic [27:0] quo_in, low_in;
    logic [32:0] sh;
    logic [31:0] rem_d;
    logic        bit_d;

    if (k == 0) begin : g_first
      assign rem_in = num_i[47:16];
      assign quo_in = '0;
      assign den_in = den_i;
      assign low_in = {num_i[15:0], 12'd0};
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign quo_in = quo_q[k-1];
      assign den_in = den_q[k-1];
      assign low_in = low_q[k-1];
    end

    always_comb begin
      sh = {rem_in, low_in[DivStages-1-k]};
      if (sh >= {1'b0, den_in}) begin
        rem_d = 32'(sh - {1'b0, den_in});
        bit_d = 1'b1;
      end else begin
        rem_d = sh[31:0];
        bit_d = 1'b0;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= rem_d;
        quo_q[k] <= {quo_in[26:0], bit_d};
        den_q[k] <= den_in;
        low_q[k] <= low_in;
      end
    end
  end

  assign quo_o = quo_q[DivStages-1];

endmodule

[design/umwb_back.sv]
// Back end: wall test, heading reflection, final move with saturation.
// Depends on umwb_pkg.
module umwb_back (
  input  logic              clk_i,
  input  logic              en_i,
  input  umwb_pkg::item_t   item_i,
  input  logic [2:0][27:0]  quo_i,
  input  logic [2:0][27:0]  quo_alt_i,
  input  logic [2:0][30:0]  bound_i,
  output logic [2:0][31:0]  pos_o,
  output logic [2:0][15:0]  dir_o
);
  import umwb_pkg::*;

  logic [2:0][15:0] dir_d, dir1_q, dir2_q;
  logic [2:0][28:0] step_d, step_q;
  logic [2:0][31:0] pos1_q, pos2_q, pos_d;
  logic             move_q;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      logic signed [33:0] dlt, nxt;
      logic               flip;
      logic [27:0]        qsel;
      dlt = item_i.dir[a][15] ? -$signed({6'd0, quo_i[a]}) : $signed({6'd0, quo_i[a]});
      nxt = $signed({{2{item_i.pos[a][31]}}, item_i.pos[a]}) + dlt;
      flip = nxt[33] || (nxt > $signed({3'd0, bound_i[a]}));
      if (!item_i.move || !flip) begin
        dir_d[a] = item_i.dir[a];
        qsel = quo_i[a];
      end else if ($signed(item_i.dir[a]) == DirMin) begin
        dir_d[a] = DirMax;
        qsel = quo_alt_i[a];
      end else begin
        dir_d[a] = 16'(~item_i.dir[a] + 16'd1);
        qsel = quo_i[a];
      end
      step_d[a] = dir_d[a][15] ? 29'(-$signed({1'b0, qsel})) : {1'b0, qsel};
    end
  end

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      logic signed [33:0] sum;
      sum = $signed({{2{pos1_q[a][31]}}, pos1_q[a]})
          + $signed({{5{step_q[a][28]}}, step_q[a]});
      if (!move_q) begin
        pos_d[a] = pos1_q[a];
      end else if (sum[33:31] == 3'b000 || sum[33:31] == 3'b111) begin
        pos_d[a] = sum[31:0];
      end else begin
        pos_d[a] = sum[33] ? 32'h8000_0000 : 32'h7fff_ffff;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dir1_q <= dir_d;
      step_q <= step_d;
      pos1_q <= item_i.pos;
      move_q <= item_i.move;
      dir2_q <= dir1_q;
      pos2_q <= pos_d;
    end
  end

  assign pos_o = pos2_q;
  assign dir_o = dir2_q;

endmodule

[sim/tb.sv]
// Self-checking bench for unit_move_with_wall_bounce: queued driver, monitor, predictor.
// Depends on umwb_pkg and the RTL of the block.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import umwb_pkg::*;

  typedef struct packed {
    logic signed [31:0] px, py, pz;
    logic signed [15:0] dx, dy, dz;
    logic [15:0]        spd;
    logic               act;
  } unit_t;

  typedef struct packed {
    logic signed [31:0] px, py, pz;
    logic signed [15:0] dx, dy, dz;
  } moved_t;

  logic clk_i, rst_ni;
  logic in_valid_i, in_stall_o;
  logic [31:0] pos_x_i, pos_y_i, pos_z_i;
  logic [15:0] dir_x_i, dir_y_i, dir_z_i, speed_i;
  logic active_i;
  logic out_valid_o, out_stall_i;
  logic [31:0] new_pos_x_o, new_pos_y_o, new_pos_z_o;
  logic [15:0] new_dir_x_o, new_dir_y_o, new_dir_z_o;
  logic cfg_valid_i, cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  unit_move_with_wall_bounce dut (.*);

  // Predictor copy of the registers
  logic [15:0] step_q88;
  logic [30:0] box_x, box_y, box_z;

  unit_t  pending_units[$];
  moved_t expected_moves[$];
  int     errors = 0;
  int     cycles = 0;
  int     send_idle_pct = 0, recv_idle_pct = 0;
  bit     hold_send = 0;
  bit     in_took = 0;

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  // Integer square root of a 64-bit value, bit by bit.
  function automatic logic [63:0] root64(logic [63:0] x);
    logic [63:0] r, b;
    r = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint axis_delta(logic [63:0] p, longint d, logic [63:0] nq);
    logic [63:0] mag, q;
    mag = (d < 0) ? -d : d;
    q = ((p * mag) << 12) / nq;
    return (d < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic moved_t move_unit(unit_t u);
    moved_t m;
    longint pos[3], dir[3], res[3], lim[3], nxt;
    logic [63:0] s, nq, p;
    pos[0] = u.px; pos[1] = u.py; pos[2] = u.pz;
    dir[0] = u.dx; dir[1] = u.dy; dir[2] = u.dz;
    lim[0] = box_x; lim[1] = box_y; lim[2] = box_z;
    for (int a = 0; a < 3; a++) res[a] = pos[a];
    if (u.act && (dir[0] != 0 || dir[1] != 0 || dir[2] != 0)) begin
      p = 64'(u.spd) * 64'(step_q88);
      s = 64'(dir[0] * dir[0] + dir[1] * dir[1] + dir[2] * dir[2]);
      nq = root64(s << 32);
      for (int a = 0; a < 3; a++) begin
        nxt = pos[a] + axis_delta(p, dir[a], nq);
        // bounce: flip heading, -32768 saturates to the max
        if (nxt < 0 || nxt > lim[a]) dir[a] = (dir[a] == -32768) ? 32767 : -dir[a];
        res[a] = pos[a] + axis_delta(p, dir[a], nq);
        if (res[a] > 64'sd2147483647) res[a] = 64'sd2147483647;
        if (res[a] < -64'sd2147483648) res[a] = -64'sd2147483648;
      end
    end
    m.px = res[0][31:0]; m.py = res[1][31:0]; m.pz = res[2][31:0];
    m.dx = dir[0][15:0]; m.dy = dir[1][15:0]; m.dz = dir[2][15:0];
    return m;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("tb: mismatch %s got %h want %h", what, got, want);
    errors++;
  endtask

  // Take each accepted input word into the prediction queue at the accepting edge.
  always @(posedge clk_i) begin
    in_took = rst_ni && in_valid_i && !in_stall_o;
    if (in_took) begin
      expected_moves.insert(expected_moves.size(), move_unit(pending_units.pop_front()));
    end
  end

  // Driver: present the next queued word at the falling edge, hold it while stalled.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_took || !in_valid_i) begin
        if (pending_units.size() > 0 && !hold_send &&
            $urandom_range(99, 0) >= send_idle_pct) begin
          pos_x_i <= pending_units[0].px; pos_y_i <= pending_units[0].py;
          pos_z_i <= pending_units[0].pz; dir_x_i <= pending_units[0].dx;
          dir_y_i <= pending_units[0].dy; dir_z_i <= pending_units[0].dz;
          speed_i <= pending_units[0].spd; active_i <= pending_units[0].act;
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_stall_i <= ($urandom_range(99, 0) < recv_idle_pct);
    end
  end

  // Monitor: compare each accepted output word with the oldest expectation.
  always @(posedge clk_i) begin
    moved_t w;
    cycles++;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_moves.size() == 0) begin
        $display("tb: unexpected output word");
        errors++;
      end else begin
        w = expected_moves.pop_front();
        if (new_pos_x_o !== w.px) report_mismatch("new_pos_x", new_pos_x_o, w.px);
        if (new_pos_y_o !== w.py) report_mismatch("new_pos_y", new_pos_y_o, w.py);
        if (new_pos_z_o !== w.pz) report_mismatch("new_pos_z", new_pos_z_o, w.pz);
        if (new_dir_x_o !== w.dx) report_mismatch("new_dir_x", new_dir_x_o, w.dx);
        if (new_dir_y_o !== w.dy) report_mismatch("new_dir_y", new_dir_y_o, w.dy);
        if (new_dir_z_o !== w.dz) report_mismatch("new_dir_z", new_dir_z_o, w.dz);
      end
    end
    if (cycles > 400000) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Write one register through the config channel; the model ignores stray indexes.
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [31:0] val);
    @(negedge clk_i);
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CfgTimeStep: step_q88 = val[15:0];
      CfgBoundX:   box_x = val[30:0];
      CfgBoundY:   box_y = val[30:0];
      CfgBoundZ:   box_z = val[30:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic drain();
    wait (pending_units.size() == 0 && !in_valid_i);
    wait (expected_moves.size() == 0);
    repeat (70) @(posedge clk_i);
  endtask

  function automatic unit_t rand_unit();
    unit_t u;
    logic [159:0] raw;
    logic [3:0] k;
    k = 4'($urandom_range(15, 0));
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
    u = raw[$bits(unit_t)-1:0];
    // mostly units inside the box
    if (k < 10) begin
      u.px = $urandom_range(box_x, 0); u.py = $urandom_range(box_y, 0);
      u.pz = $urandom_range(box_z, 0);
      u.act = ($urandom_range(9, 0) != 0);
    end
    if (k == 11) begin u.dx = 16'h0; u.dy = 16'h0; u.dz = 16'h0; end
    if (k == 12) u.dx = DirMin;
    if (k == 13) u.spd = 16'h0;
    if (k == 14) begin u.px = 32'sh7fff_ff00; u.spd = 16'hffff; u.act = 1'b1; end
    return u;
  endfunction

  task automatic add_unit(logic [31:0] x, y, z, logic [15:0] a, b, c, s, logic act);
    unit_t u;
    u.px = x; u.py = y; u.pz = z; u.dx = a; u.dy = b; u.dz = c; u.spd = s; u.act = act;
    pending_units.insert(pending_units.size(), u);
  endtask

  task automatic random_phase(int n);
    for (int i = 0; i < n; i++) pending_units.insert(pending_units.size(), rand_unit());
  endtask

  initial begin
    in_valid_i = 0; out_stall_i = 0; cfg_valid_i = 0; cfg_index_i = '0; cfg_data_i = '0;
    {pos_x_i, pos_y_i, pos_z_i, dir_x_i, dir_y_i, dir_z_i, speed_i, active_i} = '0;
    step_q88 = 16'd256; box_x = 31'd16777216; box_y = 31'd16777216; box_z = 31'd16777216;
    rst_ni = 0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;
    send_idle_pct = 38; recv_idle_pct = 83;

    // Directed: extremes, bounces, inactive, zero heading, zero speed, -32768 flip.
    add_unit(32'h0010_0000, 32'h0010_0000, 32'h0010_0000, 16'd1, 16'd2, 16'd3,
             16'h0100, 1'b1);
    add_unit(32'h0010_0000, 32'h0, 32'h0, 16'h7fff, 16'h8000, 16'h8000, 16'hffff, 1'b1);
    add_unit(32'h8000_0000, 32'h7fff_ffff, 32'h0, 16'h8000, 16'h7fff, 16'h0001,
             16'hffff, 1'b1);
    add_unit(32'h0123_4567, 32'h0089_abcd, 32'h00ef_0123, 16'h1234, 16'h4321, 16'h7777,
             16'h8000, 1'b0);
    add_unit(32'hffff_ffff, 32'h8000_0000, 32'h7fff_ffff, 16'h0, 16'h0, 16'h0,
             16'hffff, 1'b1);
    add_unit(32'hffff_f000, 32'h0100_1000, 32'h0000_0000, 16'h0005, 16'hfffb, 16'h0000,
             16'h0, 1'b1);
    add_unit(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 16'h7fff, 16'h7fff, 16'h7fff,
             16'hffff, 1'b1);
    add_unit(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 16'h8000, 16'h8000, 16'h8000,
             16'hffff, 1'b1);
    add_unit(32'h00ff_ffff, 32'h0000_0001, 32'h0080_0000, 16'hffff, 16'h0001, 16'h8000,
             16'h0001, 1'b1);
    drain();

    write_reg(CfgTimeStep, 32'hffff);
    write_reg(CfgBoundX, 32'h7fff_ffff);
    write_reg(CfgBoundY, 32'hffff_ffff);
    write_reg(CfgBoundZ, 32'h0);
    write_reg(8'd9, 32'h1234);
    add_unit(32'h7fff_0000, 32'h7fff_0000, 32'h0, 16'h7fff, 16'h7fff, 16'h0001,
             16'hffff, 1'b1);
    add_unit(32'h0, 32'h0, 32'h0, 16'h0001, 16'h8000, 16'h0000, 16'hffff, 1'b1);
    random_phase(300);
    drain();

    // Pause the sender mid-stream until every result is back, then resume.
    random_phase(50);
    wait (expected_moves.size() > 0);
    hold_send = 1;
    wait (expected_moves.size() == 0);
    hold_send = 0;
    drain();

    write_reg(CfgTimeStep, 32'h0);
    write_reg(CfgBoundX, 32'h0001_0000);
    write_reg(CfgBoundY, 32'h0000_0000);
    write_reg(CfgBoundZ, 32'h0100_0000);
    random_phase(400);
    drain();

    send_idle_pct = 83; recv_idle_pct = 38;
    write_reg(CfgTimeStep, 32'h0100);
    write_reg(CfgBoundX, 32'h0100_0000);
    write_reg(CfgBoundY, 32'h0100_0000);
    write_reg(CfgBoundZ, 32'h7fff_ffff);
    random_phase(500);
    drain();

    send_idle_pct = 0; recv_idle_pct = 0;
    write_reg(CfgTimeStep, 32'h0800);
    random_phase(600);
    drain();

    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
